// ----- design/maf_pkg.sv -----
// Shared widths and defaults for the moving average filter.
package maf_pkg;

  localparam int SampleW      = 16;
  localparam int CfgW         = 6;
  localparam int CfgReset     = 20;
  localparam int DepthDefault = 32;

endpackage

// ----- design/maf_sample_if.sv -----
// Input channel carrying one sample word.
interface maf_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [maf_pkg::SampleW-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/maf_average_if.sv -----
// Result channel carrying one average word.
interface maf_average_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [maf_pkg::SampleW-1:0]   average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ----- design/maf_cfg_if.sv -----
// Configuration write channel carrying the window size.
interface maf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [maf_pkg::CfgW-1:0]      window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ----- design/moving_average_filter.sv -----
// Sliding-window mean with ring store and bit-serial divide.
//
//  channel  dir  word                     handshake
//  in_ch    in   sample, 16 bit signed    valid/ready
//  out_ch   out  average, 16 bit signed   valid/ready
//  cfg_ch   in   window_size, 6 bit       valid/ready
//
// After its sample is taken, the average word passes S_READ (sum update), S_PREP
// and S_DIV, where the restoring divider yields one quotient bit a cycle, and
// is presented from S_DONE; the next sample is taken once the block is back in S_IDLE.
// One sample is in flight at a time; a finished word waits in the output register.
// Reset and every window_size write clear position, count and sum; the store
// is not cleared. A stalled output holds the block in its last step.
module moving_average_filter #(
  parameter int WINDOW_DEPTH = maf_pkg::DepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  maf_sample_if.sink           in_ch,
  maf_average_if.source        out_ch,
  maf_cfg_if.sink              cfg_ch
);

  localparam int PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = maf_pkg::SampleW + PW;
  localparam int SCW = $clog2(SW);
  localparam int ResetSize = (maf_pkg::CfgReset == 0) ? 1 :
                             (maf_pkg::CfgReset > WINDOW_DEPTH) ? WINDOW_DEPTH :
                             maf_pkg::CfgReset;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_PREP, S_DIV, S_DONE} state_t;

  state_t                           state_r, state_nxt;
  logic [CW-1:0]                    n_r, n_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [PW-1:0]                    pos_r, pos_nxt;
  logic signed [SW-1:0]             sum_r, sum_nxt;
  logic [SCW-1:0]                   step_r, step_nxt;
  logic                             out_valid_r, out_valid_nxt;

  logic signed [maf_pkg::SampleW-1:0] sample_r;
  logic signed [maf_pkg::SampleW-1:0] rd_r;
  logic signed [maf_pkg::SampleW-1:0] avg_r;
  logic [SW-1:0]                    dq_r;
  logic [CW-1:0]                    rem_r;
  logic                             neg_r;

  logic signed [maf_pkg::SampleW-1:0] mem [WINDOW_DEPTH];

  logic                             in_acc;
  logic                             cfg_acc;
  logic                             full;
  logic                             load_out;
  logic [CW:0]                      trial;
  logic                             ge;
  logic [SW-1:0]                    quot;
  logic [CW-1:0]                    cfg_size;

  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign full         = (cnt_r >= n_r);
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.average = avg_r;

  assign trial = {rem_r, dq_r[SW-1]};
  assign ge    = (trial >= {1'b0, cnt_r});
  assign quot  = neg_r ? (~dq_r + SW'(1)) : dq_r;

  always_comb begin
    if (cfg_ch.window_size == '0) begin
      cfg_size = CW'(1);
    end else if (32'(cfg_ch.window_size) > 32'(WINDOW_DEPTH)) begin
      cfg_size = CW'(WINDOW_DEPTH);
    end else begin
      cfg_size = CW'(cfg_ch.window_size);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          n_nxt   = cfg_size;
          cnt_nxt = '0;
          pos_nxt = '0;
          sum_nxt = '0;
        end else if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        sum_nxt = sum_r + SW'(sample_r) - (full ? SW'(rd_r) : SW'(0));
        if (!full) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (CW'(pos_r) + CW'(1) >= n_r) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
        state_nxt = S_PREP;
      end
      S_PREP: begin
        step_nxt  = SCW'(SW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        step_nxt = step_r - SCW'(1);
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= CW'(ResetSize);
      cnt_r       <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      avg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        avg_r <= quot[maf_pkg::SampleW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.sample;
    end
    case (state_r)
      S_PREP: begin
        dq_r  <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
        neg_r <= sum_r[SW-1];
        rem_r <= '0;
      end
      S_DIV: begin
        dq_r  <= {dq_r[SW-2:0], ge};
        rem_r <= ge ? CW'(trial - {1'b0, cnt_r}) : CW'(trial);
      end
      default: begin
      end
    endcase
  end

  // ring store: read on acceptance, write back in the cycle after
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[pos_r];
    end
    if (state_r == S_READ) begin
      mem[pos_r] <= sample_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= n_r)
    else $error("fill count above window size");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(pos_r) < n_r)
    else $error("write position outside window");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("divide by zero count");

  a_sample_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##2 (state_r == S_DIV))
    else $error("accepted word did not reach divider");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after divide");

endmodule
